/* design/stream_find_and_replace_assert.svh */
`ifndef STREAM_FIND_AND_REPLACE_ASSERT_SVH
`define STREAM_FIND_AND_REPLACE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SFR_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SFR_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/sfr_pkg.sv */
package sfr_pkg;

	localparam int MAX_LEN   = 8;
	localparam int BYTE_W    = 8;
	localparam int TEXT_W    = MAX_LEN * BYTE_W;
	localparam int LEN_W     = 4;
	localparam int CNT_W     = $clog2(MAX_LEN);
	localparam int REG_IDX_W = 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SEARCH_PATTERN     = 2'd0,
		REG_SEARCH_LENGTH      = 2'd1,
		REG_REPLACEMENT_TEXT   = 2'd2,
		REG_REPLACEMENT_LENGTH = 2'd3
	} sfr_reg_t;

	typedef struct packed {
		logic load;
		logic eval;
		logic emit;
	} sfr_cmd_t;

	typedef struct packed {
		logic k_zero;
		logic last;
	} sfr_status_t;

	// length 0 acts as 1, above MAX_LEN acts as MAX_LEN
	function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] r;
		if (len == '0) begin
			r = LEN_W'(1);
		end else if (len > LEN_W'(MAX_LEN)) begin
			r = LEN_W'(MAX_LEN);
		end else begin
			r = len;
		end
		return r;
	endfunction

endpackage

/* design/sfr_datapath.sv */
`include "stream_find_and_replace_assert.svh"

module sfr_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [sfr_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [sfr_pkg::TEXT_W-1:0]          cfg_data,
	input  logic [sfr_pkg::BYTE_W-1:0]          data_byte,
	input  logic                                end_of_stream,
	input  sfr_pkg::sfr_cmd_t                   cmd,
	output sfr_pkg::sfr_status_t                status,
	output logic [sfr_pkg::BYTE_W-1:0]          out_byte,
	output logic                                last_of_run
);
	import sfr_pkg::*;

	logic [TEXT_W-1:0] pat_q;
	logic [LEN_W-1:0]  slen_q;
	logic [TEXT_W-1:0] rep_q;
	logic [LEN_W-1:0]  rlen_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [BYTE_W-1:0] buf_q [MAX_LEN];
	logic [LEN_W-1:0]  n_q;
	logic              eos_q;
	logic              match_q;
	logic [LEN_W-1:0]  k_q;
	logic [CNT_W-1:0]  idx_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              last_q;

	logic [LEN_W-1:0]   slen_eff;
	logic [LEN_W-1:0]   rlen_eff;
	logic [LEN_W-1:0]   held_lim;
	logic [CNT_W-1:0]   ni;
	logic [MAX_LEN-1:0] ok;
	logic [LEN_W-1:0]   start_c;
	logic               match_c;
	logic [LEN_W-1:0]   k_c;
	logic [CNT_W-1:0]   held_c;

	assign slen_eff = eff_len(slen_q);
	assign rlen_eff = eff_len(rlen_q);
	assign held_lim = slen_eff - LEN_W'(1);
	assign ni = ({1'b0, cnt_q} > held_lim) ? held_lim[CNT_W-1:0] : cnt_q;

	// ok[s]: held bytes from s onward are a prefix of the pattern
	always_comb begin
		for (int s = 0; s < MAX_LEN; s++) begin
			ok[s] = 1'b1;
			for (int i = 0; i < MAX_LEN - s; i++) begin
				if ((s + i) < int'(n_q) && buf_q[s+i] != pat_q[i*BYTE_W +: BYTE_W]) begin
					ok[s] = 1'b0;
				end
			end
		end
	end

	always_comb begin
		start_c = LEN_W'(MAX_LEN);
		for (int s = MAX_LEN - 1; s >= 0; s--) begin
			if (ok[s]) begin
				start_c = LEN_W'(s);
			end
		end
	end

	assign match_c = (n_q == slen_eff) && ok[0];
	assign k_c     = match_c ? rlen_eff : (eos_q ? n_q : start_c);
	assign held_c  = (match_c || eos_q) ? '0 : CNT_W'(n_q - start_c);

	assign status.k_zero = (k_c == '0);
	assign status.last   = ({1'b0, idx_q} == (k_q - LEN_W'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q  <= '0;
			slen_q <= LEN_W'(1);
			rep_q  <= '0;
			rlen_q <= LEN_W'(1);
			cnt_q  <= '0;
		end else begin
			if (cfg_write) begin
				unique case (sfr_reg_t'(cfg_index))
					REG_SEARCH_PATTERN: begin
						pat_q <= cfg_data;
						cnt_q <= '0;
					end
					REG_SEARCH_LENGTH: begin
						slen_q <= cfg_data[LEN_W-1:0];
						cnt_q  <= '0;
					end
					REG_REPLACEMENT_TEXT: begin
						rep_q <= cfg_data;
					end
					REG_REPLACEMENT_LENGTH: begin
						rlen_q <= cfg_data[LEN_W-1:0];
					end
				endcase
			end else if (cmd.eval) begin
				cnt_q <= held_c;
			end
		end
	end

	// emitted bytes shift out of the front; what stays is the held prefix
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			buf_q[ni] <= data_byte;
			n_q       <= LEN_W'(ni) + LEN_W'(1);
			eos_q     <= end_of_stream;
		end
		if (cmd.eval) begin
			match_q <= match_c;
			k_q     <= k_c;
			idx_q   <= '0;
		end
		if (cmd.emit) begin
			if (match_q) begin
				out_byte_q <= rep_q[{idx_q, 3'b000} +: BYTE_W];
			end else begin
				out_byte_q <= buf_q[0];
				for (int j = 0; j < MAX_LEN - 1; j++) begin
					buf_q[j] <= buf_q[j+1];
				end
			end
			last_q <= status.last;
			idx_q  <= idx_q + CNT_W'(1);
		end
	end

	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;

	`SFR_ASSERT_IMP(a_held_fits, 1'b1, {1'b0, cnt_q} < slen_eff, "held count reaches pattern length")
	`SFR_ASSERT_IMP(a_emit_in_run, cmd.emit, {1'b0, idx_q} < k_q, "emit past end of run")

endmodule

/* design/sfr_ctrl.sv */
`include "stream_find_and_replace_assert.svh"

module sfr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sfr_pkg::sfr_cmd_t    cmd,
	input  sfr_pkg::sfr_status_t status
);
	import sfr_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;

	assign in_ready  = (state_q == ST_IDLE);
	assign cmd.load  = (state_q == ST_IDLE) && in_valid;
	assign cmd.eval  = (state_q == ST_EVAL);
	assign cmd.emit  = (state_q == ST_EMIT) && slot_free;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					state_q <= status.k_zero ? ST_IDLE : ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free && status.last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			out_valid_q <= cmd.emit || (out_valid_q && !out_ready);
		end
	end

	`SFR_ASSERT_NXT(a_last_frees, cmd.emit && status.last, in_ready && out_valid, "run end not idle")
	`SFR_ASSERT_IMP(a_valid_src, $rose(out_valid_q), $past(cmd.emit), "output valid without emit")

endmodule

/* design/stream_find_and_replace.sv */
// A request is loaded into the hold buffer, evaluated in ST_EVAL, then emitted in ST_EMIT to the output register.
// A new request is accepted only after all k results of the last one are emitted (none when k is 0);
// the output register takes one byte per cycle unless out_ready stalls it.
// Pattern and prefix offset are evaluated combinationally over the 8-byte hold buffer.
// Reset (arst_n low, async): hold buffer empty, pattern and replacement 0, lengths 1.
module stream_find_and_replace (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [sfr_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [sfr_pkg::TEXT_W-1:0]      cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [sfr_pkg::BYTE_W-1:0]      data_byte,
	input  logic                            end_of_stream,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [sfr_pkg::BYTE_W-1:0]      out_byte,
	output logic                            last_of_run
);
	import sfr_pkg::*;

	sfr_cmd_t    cmd;
	sfr_status_t status;

	sfr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	sfr_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.data_byte     (data_byte),
		.end_of_stream (end_of_stream),
		.cmd           (cmd),
		.status        (status),
		.out_byte      (out_byte),
		.last_of_run   (last_of_run)
	);

endmodule
